FILE: design/prpd_pkg.sv
`default_nettype none

package prpd_pkg;

    // Header signature in bytes 0 to 2
    localparam logic [7:0] HDR_BYTE0 = 8'h54;
    localparam logic [7:0] HDR_BYTE1 = 8'h50;
    localparam logic [7:0] HDR_BYTE2 = 8'h58;

    // Word kinds, decided on byte 7
    localparam logic [7:0] KIND_TRIGGER = 8'h6F;
    localparam logic [3:0] KIND_GTIME   = 4'h4;
    localparam logic [7:0] KIND_GT_LOW  = 8'h44;
    localparam logic [7:0] KIND_GT_HIGH = 8'h45;
    localparam logic [3:0] KIND_PIXEL   = 4'hB;

    // Layout kinds
    localparam logic [7:0] LAYOUT_SHIFT  = 8'd0;
    localparam logic [7:0] LAYOUT_FLIP   = 8'd1;
    localparam logic [7:0] LAYOUT_FLIP_X = 8'd2;

    localparam logic [9:0] X_OFFSET    = 10'd260;
    localparam logic [9:0] FLIP_FULL   = 10'd515;
    localparam logic [9:0] FLIP_HALF   = 10'd255;

    localparam int unsigned  FRAME_W            = 25;
    localparam logic [24:0]  FRAME_PERIOD_RESET = 25'd16666667;

    typedef struct packed {
        logic [9:0]  pos_x;
        logic [9:0]  pos_y;
        logic [9:0]  over_threshold;
        logic [13:0] arrival_coarse;
        logic [3:0]  arrival_fine;
        logic [47:0] pixel_time;
        logic [47:0] trigger_time;
    } pixel_t;

endpackage

`default_nettype wire

FILE: design/prpd_decode.sv
`default_nettype none

module prpd_decode
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire logic [63:0]     in_word,
    output logic                 in_ready,
    output logic                 pix_valid,
    output prpd_pkg::pixel_t     pix_data,
    input  wire logic            pix_ready
);

    logic [12:0] words_left_reg,  words_left_next;
    logic [7:0]  layout_kind_reg, layout_kind_next;
    logic [47:0] trigger_time_reg, trigger_time_next;
    logic [47:0] global_time_reg, global_time_next;
    logic [31:0] global_low_reg,  global_low_next;
    logic        pix_valid_reg,   pix_valid_next;
    prpd_pkg::pixel_t pix_data_reg, pix_data_next;

    logic        take;
    logic [7:0]  b7;
    logic        is_header;
    logic [31:0] trig_low;
    logic [15:0] trig_high;
    logic [29:0] spider;
    logic [17:0] upper;
    logic [15:0] addr;
    logic [9:0]  x_raw;
    logic [9:0]  y_raw;
    logic [9:0]  x_adj;
    logic [9:0]  y_adj;

    assign in_ready = !pix_valid_reg || pix_ready;
    assign take     = in_valid && in_ready;
    assign b7       = in_word[63:56];

    assign is_header = (in_word[7:0] == prpd_pkg::HDR_BYTE0)
                    && (in_word[15:8] == prpd_pkg::HDR_BYTE1)
                    && (in_word[23:16] == prpd_pkg::HDR_BYTE2);

    // The trigger time is extended by the upper global bits, bumped on wrap.
    assign trig_low  = in_word[43:12];
    assign trig_high = global_time_reg[47:32]
                     + {15'd0, (trig_low < global_time_reg[31:0])};

    assign spider = {in_word[15:0], in_word[43:30]};
    assign upper  = global_time_reg[47:30]
                  + {17'd0, (spider < global_time_reg[29:0])};

    assign addr  = in_word[59:44];
    assign x_raw = {2'd0, addr[15:9], addr[2]};
    assign y_raw = {2'd0, addr[8:3], addr[1:0]};

    always_comb
    begin
        unique case (layout_kind_reg)
            prpd_pkg::LAYOUT_SHIFT:
            begin
                x_adj = x_raw + prpd_pkg::X_OFFSET;
                y_adj = y_raw;
            end
            prpd_pkg::LAYOUT_FLIP:
            begin
                x_adj = prpd_pkg::FLIP_FULL - x_raw;
                y_adj = prpd_pkg::FLIP_FULL - y_raw;
            end
            prpd_pkg::LAYOUT_FLIP_X:
            begin
                x_adj = prpd_pkg::FLIP_HALF - x_raw;
                y_adj = prpd_pkg::FLIP_FULL - y_raw;
            end
            default:
            begin
                x_adj = x_raw;
                y_adj = y_raw;
            end
        endcase
    end

    always_comb
    begin
        words_left_next   = words_left_reg;
        layout_kind_next  = layout_kind_reg;
        trigger_time_next = trigger_time_reg;
        global_time_next  = global_time_reg;
        global_low_next   = global_low_reg;
        pix_valid_next    = pix_valid_reg && !pix_ready;

        pix_data_next.pos_x          = x_adj;
        pix_data_next.pos_y          = y_adj;
        pix_data_next.over_threshold = in_word[29:20];
        pix_data_next.arrival_coarse = in_word[43:30];
        pix_data_next.arrival_fine   = in_word[19:16];
        pix_data_next.pixel_time     = {upper, spider};
        pix_data_next.trigger_time   = trigger_time_reg;

        if (take)
        begin
            if (words_left_reg == 13'd0)
            begin
                if (is_header)
                begin
                    // Byte count in bytes 7:6, divided by eight
                    words_left_next  = in_word[63:51];
                    layout_kind_next = in_word[39:32];
                end
            end
            else
            begin
                words_left_next = words_left_reg - 13'd1;
                priority if (b7 == prpd_pkg::KIND_TRIGGER)
                begin
                    trigger_time_next = {trig_high, trig_low};
                end
                else if (b7[7:4] == prpd_pkg::KIND_GTIME)
                begin
                    if (b7 == prpd_pkg::KIND_GT_LOW)
                    begin
                        global_low_next = in_word[47:16];
                    end
                    else if (b7 == prpd_pkg::KIND_GT_HIGH)
                    begin
                        global_time_next = {in_word[31:16], global_low_reg};
                    end
                end
                else if (b7[7:4] == prpd_pkg::KIND_PIXEL)
                begin
                    pix_valid_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            words_left_reg   <= '0;
            layout_kind_reg  <= '0;
            trigger_time_reg <= '0;
            global_time_reg  <= '0;
            global_low_reg   <= '0;
            pix_valid_reg    <= 1'b0;
        end
        else
        begin
            words_left_reg   <= words_left_next;
            layout_kind_reg  <= layout_kind_next;
            trigger_time_reg <= trigger_time_next;
            global_time_reg  <= global_time_next;
            global_low_reg   <= global_low_next;
            pix_valid_reg    <= pix_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            pix_data_reg <= pix_data_next;
        end
    end

    assign pix_valid = pix_valid_reg;
    assign pix_data  = pix_data_reg;

`ifndef SYNTHESIS
    // Every word taken inside a batch uses up one count.
    assert property (@(posedge clk) disable iff (!rst_n)
        take && (words_left_reg != 13'd0)
        |=> words_left_reg == $past(words_left_reg) - 13'd1)
        else $error("batch count did not step down");

    // A word taken outside a batch never yields a pixel.
    assert property (@(posedge clk) disable iff (!rst_n)
        take && (words_left_reg == 13'd0) |=> !pix_valid_reg)
        else $error("pixel produced outside a batch");

    // The layout only changes on a header outside a batch.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(take && (words_left_reg == 13'd0)) |=> $stable(layout_kind_reg))
        else $error("layout changed without a header");
`endif

endmodule

`default_nettype wire

FILE: design/prpd_flight.sv
`default_nettype none

module prpd_flight
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [prpd_pkg::FRAME_W-1:0] frame_period,
    input  wire logic                         in_valid,
    input  wire prpd_pkg::pixel_t             in_data,
    output logic                              in_ready,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // pos_x, pos_y, over_threshold, arrival_coarse, arrival_fine,
    // flight_time, pixel_time
    output logic [127:0]                      m_tdata
);

    logic         out_valid_reg, out_valid_next;
    logic [127:0] out_data_reg,  out_data_next;
    logic         take;
    logic         wrapped;
    logic [31:0]  flight;

    assign in_ready = !out_valid_reg || m_tready;
    assign take     = in_valid && in_ready;

    // A pixel before its trigger belongs to the next frame.
    assign wrapped = in_data.pixel_time < in_data.trigger_time;
    assign flight  = in_data.pixel_time[31:0] - in_data.trigger_time[31:0]
                   + (wrapped ? {7'd0, frame_period} : 32'd0);

    always_comb
    begin
        out_valid_next = take || (out_valid_reg && !m_tready);
        out_data_next  = {in_data.pixel_time, flight, in_data.arrival_fine,
                          in_data.arrival_coarse, in_data.over_threshold,
                          in_data.pos_y, in_data.pos_x};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTHESIS
    // Back-pressure here can only come from a stalled result word.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid_reg && !m_tready))
        else $error("stage stalled without a pending word");
`endif

endmodule

`default_nettype wire

FILE: design/pixel_readout_packet_decoder_top.sv
// A result word passes the input, decode and flight registers on its way to m_tvalid.
// Throughput: one input word per cycle while m_tready does not stall the output, set by
// the single decode stage that updates the batch and time state for each word.
// Reset (rst_n, asynchronous, active low) clears all pipeline valids, the batch count,
// layout and times, and loads frame_period with 16666667.
`default_nettype none

module pixel_readout_packet_decoder_top
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_wr_en,
    input  wire logic [prpd_pkg::FRAME_W-1:0] cfg_wr_data,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    // word
    input  wire logic [63:0]                  s_tdata,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // pos_x, pos_y, over_threshold, arrival_coarse, arrival_fine,
    // flight_time, pixel_time
    output logic [127:0]                      m_tdata
);

    logic                         in_valid_reg, in_valid_next;
    logic [63:0]                  in_word_reg;
    logic [prpd_pkg::FRAME_W-1:0] frame_period_reg;
    logic                         dec_ready;
    logic                         pix_valid;
    logic                         pix_ready;
    prpd_pkg::pixel_t             pix_data;

    assign s_tready      = !in_valid_reg || dec_ready;
    assign in_valid_next = (s_tvalid && s_tready) || (in_valid_reg && !dec_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            frame_period_reg <= prpd_pkg::FRAME_PERIOD_RESET;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (cfg_wr_en)
            begin
                frame_period_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_word_reg <= s_tdata;
        end
    end

    prpd_decode u_decode
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid_reg),
        .in_word   (in_word_reg),
        .in_ready  (dec_ready),
        .pix_valid (pix_valid),
        .pix_data  (pix_data),
        .pix_ready (pix_ready)
    );

    prpd_flight u_flight
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_period (frame_period_reg),
        .in_valid     (pix_valid),
        .in_data      (pix_data),
        .in_ready     (pix_ready),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

endmodule

`default_nettype wire

FILE: sim/pixel_readout_packet_decoder_top_tb.sv
`timescale 1ns / 100ps

module pixel_readout_packet_decoder_top_tb;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int PHASE_WORDS   = 365;
    localparam int PHASE_COUNT   = 5;
    localparam int SETTLE_CYCLES = 8;

    // One decoded pixel hit, laid out as on m_tdata (pos_x in the lowest bits).
    typedef struct packed {
        logic [47:0] pixel_time;
        logic [31:0] flight_time;
        logic [3:0]  arrival_fine;
        logic [13:0] arrival_coarse;
        logic [9:0]  over_threshold;
        logic [9:0]  pos_y;
        logic [9:0]  pos_x;
    } pixel_hit_t;

    class pixel_scoreboard;
        logic [24:0] frame_period;
        logic [12:0] words_left;
        logic [7:0]  layout_kind;
        logic [47:0] trigger_time;
        logic [47:0] global_time;
        logic [31:0] global_low;
        pixel_hit_t  hits_due[$];
        int          errors;
        int          hits_checked;

        function new();
            frame_period = prpd_pkg::FRAME_PERIOD_RESET;
            words_left   = '0;
            layout_kind  = '0;
            trigger_time = '0;
            global_time  = '0;
            global_low   = '0;
            errors       = 0;
            hits_checked = 0;
        endfunction

        function void set_frame_period(logic [24:0] value);
            frame_period = value;
        endfunction

        // Advances the decoder state by one accepted word and queues any hit it makes.
        function void note_word(logic [63:0] w);
            logic [7:0]  kind;
            logic [31:0] trig_low;
            logic [15:0] trig_high;
            logic [29:0] spider;
            logic [17:0] upper;
            logic [47:0] ptime;
            logic [31:0] flight;
            logic [15:0] addr;
            int          x;
            int          y;
            pixel_hit_t  hit;

            kind = w[63:56];
            if (words_left == 0)
            begin
                if (w[7:0] == prpd_pkg::HDR_BYTE0 && w[15:8] == prpd_pkg::HDR_BYTE1
                    && w[23:16] == prpd_pkg::HDR_BYTE2)
                begin
                    words_left  = w[63:51];
                    layout_kind = w[39:32];
                end
                return;
            end
            words_left = words_left - 13'd1;

            if (kind == prpd_pkg::KIND_TRIGGER)
            begin
                trig_low  = w[43:12];
                trig_high = global_time[47:32];
                if (trig_low < global_time[31:0])
                    trig_high = trig_high + 16'd1;
                trigger_time = {trig_high, trig_low};
                return;
            end
            if (kind[7:4] == prpd_pkg::KIND_GTIME)
            begin
                if (kind == prpd_pkg::KIND_GT_LOW)
                    global_low = w[47:16];
                else if (kind == prpd_pkg::KIND_GT_HIGH)
                    global_time = {w[31:16], global_low};
                return;
            end
            if (kind[7:4] != prpd_pkg::KIND_PIXEL)
                return;

            spider = {w[15:0], w[43:30]};
            upper  = global_time[47:30];
            if (spider < global_time[29:0])
                upper = upper + 18'd1;
            ptime  = {upper, spider};
            flight = ptime[31:0] - trigger_time[31:0];
            if (ptime < trigger_time)
                flight = flight + 32'(frame_period);

            addr = w[59:44];
            x = int'(addr[15:9]) * 2 + int'(addr[2]);
            y = int'(addr[8:3]) * 4 + int'(addr[1:0]);
            if (layout_kind == prpd_pkg::LAYOUT_SHIFT)
                x = x + int'(prpd_pkg::X_OFFSET);
            else if (layout_kind == prpd_pkg::LAYOUT_FLIP)
            begin
                x = int'(prpd_pkg::FLIP_FULL) - x;
                y = int'(prpd_pkg::FLIP_FULL) - y;
            end
            else if (layout_kind == prpd_pkg::LAYOUT_FLIP_X)
            begin
                x = int'(prpd_pkg::FLIP_HALF) - x;
                y = int'(prpd_pkg::FLIP_FULL) - y;
            end

            hit.pos_x          = x[9:0];
            hit.pos_y          = y[9:0];
            hit.over_threshold = w[29:20];
            hit.arrival_coarse = w[43:30];
            hit.arrival_fine   = w[19:16];
            hit.flight_time    = flight;
            hit.pixel_time     = ptime;
            hits_due = {hits_due, hit};
        endfunction

        task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
            errors++;
            $display("%0t mismatch in %s: got %h, expected %h", $realtime, what, got, want);
        endtask

        task check_result(logic [127:0] data);
            pixel_hit_t got;
            pixel_hit_t want;

            got = data;
            if (hits_due.size() == 0)
            begin
                report_mismatch("unexpected result word", data[63:0], '0);
                return;
            end
            want = hits_due.pop_front();
            hits_checked++;
            if (got.pos_x != want.pos_x)
                report_mismatch("pos_x", got.pos_x, want.pos_x);
            if (got.pos_y != want.pos_y)
                report_mismatch("pos_y", got.pos_y, want.pos_y);
            if (got.over_threshold != want.over_threshold)
                report_mismatch("over_threshold", got.over_threshold, want.over_threshold);
            if (got.arrival_coarse != want.arrival_coarse)
                report_mismatch("arrival_coarse", got.arrival_coarse, want.arrival_coarse);
            if (got.arrival_fine != want.arrival_fine)
                report_mismatch("arrival_fine", got.arrival_fine, want.arrival_fine);
            if (got.flight_time != want.flight_time)
                report_mismatch("flight_time", got.flight_time, want.flight_time);
            if (got.pixel_time != want.pixel_time)
                report_mismatch("pixel_time", got.pixel_time, want.pixel_time);
        endtask
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_wr_en;
    logic [prpd_pkg::FRAME_W-1:0]  cfg_wr_data;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [63:0]                   s_tdata;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [127:0]                  m_tdata;

    pixel_scoreboard     sb;
    bit                  gaps_on;
    int                  words_sent;
    int                  batches_sent;
    int                  periods_used;
    int                  cycle_count;

    pixel_readout_packet_decoder_top dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("pixel_readout_packet_decoder_top regression: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // The receiver stalls in random bursts while gaps are enabled.
    initial
    begin
        m_tready = 1'b0;
        @(negedge clk);
        forever
        begin
            if (gaps_on && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge clk);
            end
            m_tready <= 1'b1;
            @(negedge clk);
        end
    end

    function automatic logic [63:0] header_word(int unsigned count, logic [7:0] layout);
        logic [15:0] size;

        size = {count[12:0], 3'($urandom)};
        return {size, 8'($urandom), layout, 8'($urandom),
                prpd_pkg::HDR_BYTE2, prpd_pkg::HDR_BYTE1, prpd_pkg::HDR_BYTE0};
    endfunction

    function automatic logic [63:0] pixel_word(logic [15:0] addr, logic [13:0] toa,
                                               logic [9:0] tot, logic [3:0] fine,
                                               logic [15:0] spider_hi);
        return {prpd_pkg::KIND_PIXEL, addr, toa, tot, fine, spider_hi};
    endfunction

    function automatic logic [63:0] trigger_word(logic [31:0] stamp);
        return {prpd_pkg::KIND_TRIGGER, 12'($urandom), stamp, 12'($urandom)};
    endfunction

    function automatic logic [63:0] gtime_low_word(logic [31:0] value);
        return {prpd_pkg::KIND_GT_LOW, 8'($urandom), value, 16'($urandom)};
    endfunction

    function automatic logic [63:0] gtime_high_word(logic [15:0] value);
        return {prpd_pkg::KIND_GT_HIGH, 24'($urandom), value, 16'($urandom)};
    endfunction

    // A word of no known kind: not a trigger, not a global time, not a pixel.
    function automatic logic [63:0] filler_word();
        logic [63:0] w;

        do
            w = {$urandom, $urandom};
        while (w[63:56] == prpd_pkg::KIND_TRIGGER || w[63:60] == prpd_pkg::KIND_GTIME
               || w[63:60] == prpd_pkg::KIND_PIXEL);
        return w;
    endfunction

    function automatic logic [63:0] random_data_word();
        int unsigned pick;

        pick = $urandom_range(0, 99);
        if (pick < 45)
            return pixel_word(16'($urandom), 14'($urandom), 10'($urandom),
                              4'($urandom), 16'($urandom));
        if (pick < 60)
            return trigger_word($urandom);
        if (pick < 70)
            return gtime_low_word($urandom);
        if (pick < 80)
            return gtime_high_word(16'($urandom));
        if (pick < 84)
            return {prpd_pkg::KIND_GTIME, 4'($urandom), 56'({$urandom, $urandom})};
        if (pick < 92)
            return filler_word();
        if (pick < 96)
            return header_word($urandom_range(0, 40), 8'($urandom));
        return {$urandom, $urandom};
    endfunction

    // Called at a falling edge; returns at the falling edge after the word is taken,
    // with tvalid still high.
    task send_word(logic [63:0] w);
        if (gaps_on && $urandom_range(0, 7) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_word(w);
        words_sent++;
        @(negedge clk);
    endtask

    task wait_drained();
        s_tvalid <= 1'b0;
        while (sb.hits_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task write_frame_period(logic [24:0] value);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        sb.set_frame_period(value);
        periods_used++;
    endtask

    task run_batch();
        int unsigned count;
        int unsigned data_words;
        int unsigned shape;
        logic [7:0]  layout;

        count = ($urandom_range(0, 29) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 24);
        case ($urandom_range(0, 9))
            0, 1, 2: layout = prpd_pkg::LAYOUT_SHIFT;
            3, 4, 5: layout = prpd_pkg::LAYOUT_FLIP;
            6, 7, 8: layout = prpd_pkg::LAYOUT_FLIP_X;
            default: layout = 8'($urandom);
        endcase
        // Most batches are complete; some are cut short and some run over.
        shape = $urandom_range(0, 9);
        if (shape == 0)
            data_words = count - $urandom_range(1, count);
        else if (shape == 1)
            data_words = count + $urandom_range(1, 3);
        else
            data_words = count;
        send_word(header_word(count, layout));
        batches_sent++;
        repeat (data_words)
            send_word(random_data_word());
    endtask

    initial
    begin
        int phase_start;
        logic [24:0] period;

        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        gaps_on      = 1'b1;
        words_sent   = 0;
        batches_sent = 0;
        periods_used = 1;
        cycle_count  = 0;
        sb = new();
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Words outside a batch, and a header too short to open one.
        send_word(pixel_word('1, '1, '1, '1, '1));
        send_word(header_word(0, prpd_pkg::LAYOUT_SHIFT));
        send_word(trigger_word('1));

        // Global time all ones: the trigger and the pixel both wrap their upper bits.
        send_word(header_word(6, prpd_pkg::LAYOUT_SHIFT));
        send_word(gtime_low_word('1));
        send_word(gtime_high_word('1));
        send_word(trigger_word('0));
        send_word(pixel_word('1, '0, '0, '0, '0));
        send_word(header_word(5, prpd_pkg::LAYOUT_FLIP));
        send_word(filler_word());

        send_word(header_word(3, prpd_pkg::LAYOUT_FLIP));
        send_word(pixel_word('0, '0, '0, '0, '0));
        send_word(pixel_word('1, '1, '1, '1, '1));
        send_word({prpd_pkg::KIND_GTIME, 4'h7, 56'({$urandom, $urandom})});

        send_word(header_word(2, prpd_pkg::LAYOUT_FLIP_X));
        send_word(pixel_word('1, 14'h1555, 10'h2AA, 4'h5, 16'hAAAA));
        send_word(pixel_word('0, '1, '1, '1, '1));

        send_word(header_word(1, 8'hFF));
        send_word(pixel_word(16'h5A5A, '1, '0, '1, '0));

        // Pixel time before the trigger, with a zero and then the widest frame period.
        write_frame_period('0);
        send_word(header_word(4, prpd_pkg::LAYOUT_SHIFT));
        send_word(gtime_low_word('0));
        send_word(gtime_high_word('0));
        send_word(trigger_word('1));
        send_word(pixel_word('0, '0, '0, '0, '0));
        write_frame_period('1);
        send_word(header_word(1, prpd_pkg::LAYOUT_FLIP));
        send_word(pixel_word('0, '0, '0, '0, '0));

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            case (p)
                1:       period = 25'd1;
                2:       period = '1;
                3:       period = prpd_pkg::FRAME_PERIOD_RESET;
                default: period = 25'($urandom_range(1, 33554431));
            endcase
            write_frame_period(period);
            gaps_on     = (p != PHASE_COUNT - 1);
            phase_start = words_sent;
            while (words_sent - phase_start < PHASE_WORDS)
            begin
                if ($urandom_range(0, 4) == 0)
                    repeat ($urandom_range(1, 3))
                        send_word(filler_word());
                else if ($urandom_range(0, 19) == 0)
                    send_word(header_word(0, 8'($urandom)));
                else
                    run_batch();
                // In phase 2, hold the sender at mid-phase until the output has caught up.
                if (p == 2 && words_sent - phase_start >= PHASE_WORDS / 2
                    && words_sent - phase_start < PHASE_WORDS / 2 + 30)
                    wait_drained();
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        $display("Sent %0d readout words in %0d batches under %0d frame period settings,",
                 words_sent, batches_sent, periods_used);
        $display("covering all layouts, time wraps and malformed batches; %0d hits checked.",
                 sb.hits_checked);
        if (sb.errors == 0 && sb.hits_due.size() == 0)
            $display("pixel_readout_packet_decoder_top regression: pass");
        else
            $display("pixel_readout_packet_decoder_top regression: fail");
        $finish;
    end

endmodule

FILE: filelist.f
design/prpd_pkg.sv
design/prpd_decode.sv
design/prpd_flight.sv
design/pixel_readout_packet_decoder_top.sv
sim/pixel_readout_packet_decoder_top_tb.sv
